### hdl/utu_pkg.sv
package utu_pkg;

	localparam int unsigned UnitW      = 21;
	localparam int unsigned ByteW      = 8;
	localparam int unsigned JobBytes   = 7;
	localparam int unsigned CountW     = 3;
	localparam int unsigned QueueDepth = 2;

	localparam logic [UnitW-1:0] SurrHiFirst = 21'h00D800;
	localparam logic [UnitW-1:0] SurrHiLast  = 21'h00DBFF;
	localparam logic [UnitW-1:0] SurrLoFirst = 21'h00DC00;
	localparam logic [UnitW-1:0] SurrLoLast  = 21'h00DFFF;
	localparam logic [UnitW-1:0] SuppBase    = 21'h010000;
	localparam logic [UnitW-1:0] Lim1Byte    = 21'h000080;
	localparam logic [UnitW-1:0] Lim2Byte    = 21'h000800;
	localparam logic [UnitW-1:0] Lim3Byte    = 21'h010000;
	localparam logic [ByteW-1:0] Lead2       = 8'hC0;
	localparam logic [ByteW-1:0] Lead3       = 8'hE0;
	localparam logic [ByteW-1:0] Lead4       = 8'hF0;
	localparam logic [ByteW-1:0] ContMark    = 8'h80;

	typedef logic [JobBytes-1:0][ByteW-1:0] job_bytes_t;

	typedef struct packed {
		job_bytes_t        bytes;
		logic [CountW-1:0] count;
		logic              last;
	} job_t;

	typedef struct packed {
		logic [3:0][ByteW-1:0] b;
		logic [CountW-1:0]     len;
	} enc_t;

	function automatic enc_t encode(input logic [UnitW-1:0] cp);
		enc_t e;
		e.b = '0;
		if (cp < Lim1Byte) begin
			e.b[0] = cp[7:0];
			e.len  = 3'd1;
		end else if (cp < Lim2Byte) begin
			e.b[0] = Lead2 | {3'b000, cp[10:6]};
			e.b[1] = ContMark | {2'b00, cp[5:0]};
			e.len  = 3'd2;
		end else if (cp < Lim3Byte) begin
			e.b[0] = Lead3 | {4'b0000, cp[15:12]};
			e.b[1] = ContMark | {2'b00, cp[11:6]};
			e.b[2] = ContMark | {2'b00, cp[5:0]};
			e.len  = 3'd3;
		end else begin
			e.b[0] = Lead4 | {5'b00000, cp[20:18]};
			e.b[1] = ContMark | {2'b00, cp[17:12]};
			e.b[2] = ContMark | {2'b00, cp[11:6]};
			e.b[3] = ContMark | {2'b00, cp[5:0]};
			e.len  = 3'd4;
		end
		return e;
	endfunction

endpackage

### hdl/utu_front.sv
module utu_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [utu_pkg::UnitW-1:0]  code_unit,
	input  logic                       string_end,
	input  logic                       q_full,
	output logic                       q_push,
	output utu_pkg::job_t              q_job
);
	import utu_pkg::*;

	logic       held_q;
	logic [9:0] held_bits_q;
	logic       accept;
	logic       is_low;
	logic       is_high;
	logic       hold_new;
	logic       pair;
	enc_t       ea;
	enc_t       eb;
	enc_t       ep;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign is_low   = (code_unit >= SurrLoFirst) && (code_unit <= SurrLoLast);
	assign is_high  = (code_unit >= SurrHiFirst) && (code_unit <= SurrHiLast);
	assign pair     = held_q && is_low;
	assign hold_new = !pair && is_high && !string_end;

	always_comb begin
		ep = encode(SuppBase + {1'b0, held_bits_q, code_unit[9:0]});
		ea = encode({11'b0, held_bits_q} | SurrHiFirst);
		eb = encode(code_unit);
		q_job.bytes = '0;
		q_job.last  = string_end;
		if (pair) begin
			q_job.bytes[3:0] = ep.b;
			q_job.count      = ep.len;
		end else if (held_q) begin
			q_job.bytes[2:0] = ea.b[2:0];
			q_job.bytes[6:3] = eb.b;
			q_job.count      = hold_new ? 3'd3 : 3'd3 + eb.len;
		end else begin
			q_job.bytes[3:0] = eb.b;
			q_job.count      = hold_new ? 3'd0 : eb.len;
		end
	end

	assign q_push = accept && (q_job.count != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= 1'b0;
			held_bits_q <= '0;
		end else if (accept) begin
			held_q      <= hold_new;
			held_bits_q <= code_unit[9:0];
		end
	end

endmodule

### hdl/utu_queue.sv
module utu_queue #(
	parameter int unsigned Depth = utu_pkg::QueueDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  utu_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output utu_pkg::job_t head_job
);
	import utu_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full       = (count_q == CntW'(Depth));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/utu_back.sv
module utu_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      head_valid,
	input  utu_pkg::job_t             head_job,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [utu_pkg::ByteW-1:0] utf8_byte,
	output logic                      run_last,
	output logic                      text_done
);
	import utu_pkg::*;

	job_bytes_t              cur_q;
	job_bytes_t              cur_shift;
	logic [CountW-1:0]       rem_q;
	logic                    last_q;
	logic                    out_valid_q;
	logic [ByteW-1:0]        byte_q;
	logic                    run_last_q;
	logic                    text_done_q;
	logic                    adv;
	logic                    busy;
	logic                    fin;

	assign adv  = !out_valid_q || !out_stall;
	assign busy = (rem_q != '0);
	assign fin  = (rem_q == 3'd1);
	assign pop  = head_valid && (!busy || (adv && fin));

	always_comb begin
		for (int i = 0; i < JobBytes - 1; i++) begin
			cur_shift[i] = cur_q[i + 1];
		end
		cur_shift[JobBytes-1] = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= busy;
			end
			if (pop) begin
				rem_q <= head_job.count;
			end else if (adv && busy) begin
				rem_q <= rem_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && busy) begin
			byte_q      <= cur_q[0];
			run_last_q  <= fin;
			text_done_q <= fin && last_q;
		end
		if (pop) begin
			cur_q  <= head_job.bytes;
			last_q <= head_job.last;
		end else if (adv && busy) begin
			cur_q <= cur_shift;
		end
	end

	assign out_valid = out_valid_q;
	assign utf8_byte = byte_q;
	assign run_last  = run_last_q;
	assign text_done = text_done_q;

endmodule

### hdl/utf16_to_utf8_transcoder.sv
// A request's first byte passes through the job queue, the byte engine's job register and
// the output byte register. The output delivers one byte per cycle while out_stall is low; a
// request with output yields one to seven bytes, and a held high surrogate yields none.
// Requests are accepted every cycle while the two-entry job queue has room.
// Reset clears the held surrogate, the job queue and the output valid.
module utf16_to_utf8_transcoder #(
	parameter int unsigned QueueDepth = utu_pkg::QueueDepth
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [utu_pkg::UnitW-1:0] code_unit,
	input  logic                      string_end,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [utu_pkg::ByteW-1:0] utf8_byte,
	output logic                      run_last,
	output logic                      text_done
);
	import utu_pkg::*;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_head_valid;
	job_t q_job;
	job_t q_head;

	utu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_unit  (code_unit),
		.string_end (string_end),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (q_job)
	);

	utu_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_job   (q_head)
	);

	utu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_job   (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.utf8_byte  (utf8_byte),
		.run_last   (run_last),
		.text_done  (text_done)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head_valid)
		else $error("job popped from an empty queue");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && text_done) |-> run_last)
		else $error("string end flagged on a byte that does not end its request");

	a_pushed_job_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_job.count != 3'd0))
		else $error("empty job entered the queue");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import utu_pkg::*;

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned UnitTarget = 220;
	localparam int unsigned DrainCycles = 20;

	typedef struct packed {
		logic [ByteW-1:0] octet;
		logic             run_last;
		logic             text_done;
	} octet_t;

	typedef enum int {
		K_ASCII,
		K_TWO,
		K_BMP,
		K_SUPP,
		K_WIDE,
		K_PAIR,
		K_HIGH,
		K_LOW,
		K_NOISE
	} unit_kind_t;

	class utf8_scoreboard;
		logic             held_valid;
		logic [9:0]       held_bits;
		logic [ByteW-1:0] run_bytes[$];
		octet_t           pending[$];
		int               mismatches;

		function new();
			held_valid = 1'b0;
			held_bits  = '0;
			mismatches = 0;
		endfunction

		function void add_byte(logic [ByteW-1:0] b);
			run_bytes = {run_bytes, b};
		endfunction

		function void append_point(logic [UnitW-1:0] cp);
			if (cp < Lim1Byte) begin
				add_byte(cp[7:0]);
			end else if (cp < Lim2Byte) begin
				add_byte(Lead2 | {3'b000, cp[10:6]});
				add_byte(ContMark | {2'b00, cp[5:0]});
			end else if (cp < Lim3Byte) begin
				add_byte(Lead3 | {4'b0000, cp[15:12]});
				add_byte(ContMark | {2'b00, cp[11:6]});
				add_byte(ContMark | {2'b00, cp[5:0]});
			end else begin
				add_byte(Lead4 | {5'b00000, cp[20:18]});
				add_byte(ContMark | {2'b00, cp[17:12]});
				add_byte(ContMark | {2'b00, cp[11:6]});
				add_byte(ContMark | {2'b00, cp[5:0]});
			end
		endfunction

		function void note_unit(logic [UnitW-1:0] cu, logic last);
			logic   is_low;
			logic   fin;
			octet_t item;
			is_low = (cu >= SurrLoFirst) && (cu <= SurrLoLast);
			run_bytes.delete();
			if (held_valid && is_low) begin
				append_point(SuppBase + {1'b0, held_bits, cu[9:0]});
				held_valid = 1'b0;
				held_bits  = '0;
			end else begin
				if (held_valid) begin
					append_point(SurrHiFirst | {11'b0, held_bits});
					held_valid = 1'b0;
					held_bits  = '0;
				end
				if ((cu >= SurrHiFirst) && (cu <= SurrHiLast) && !last) begin
					held_valid = 1'b1;
					held_bits  = cu[9:0];
				end else begin
					append_point(cu);
				end
			end
			foreach (run_bytes[k]) begin
				fin = (k == run_bytes.size() - 1);
				item.octet     = run_bytes[k];
				item.run_last  = fin;
				item.text_done = fin && last;
				pending = {pending, item};
			end
		endfunction

		function void check_octet(logic [ByteW-1:0] b, logic rl, logic td);
			octet_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected byte %02h run_last %b text_done %b", b, rl, td);
				return;
			end
			want = pending.pop_front();
			if (want.octet !== b || want.run_last !== rl || want.text_done !== td) begin
				mismatches++;
				if (mismatches <= 10)
					$display("byte mismatch: expected %02h/%b/%b, got %02h/%b/%b",
						want.octet, want.run_last, want.text_done, b, rl, td);
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [UnitW-1:0] code_unit;
	logic             string_end;
	logic             out_valid;
	logic             out_stall;
	logic [ByteW-1:0] utf8_byte;
	logic             run_last;
	logic             text_done;

	utf8_scoreboard board = new();
	int             sent_units;
	int             got_bytes;
	int             tx_burst;
	int             rx_burst;
	int unsigned    cycles;

	utf16_to_utf8_transcoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.code_unit (code_unit),
		.string_end(string_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.utf8_byte (utf8_byte),
		.run_last  (run_last),
		.text_done (text_done)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int draw_gap(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0)
			burst = $urandom_range(5, 20);
		return $urandom_range(0, 12);
	endfunction

	function automatic unit_kind_t draw_kind();
		int r;
		r = $urandom_range(0, 19);
		if (r < 4) return K_ASCII;
		else if (r < 6) return K_TWO;
		else if (r < 9) return K_BMP;
		else if (r < 11) return K_SUPP;
		else if (r < 15) return K_PAIR;
		else if (r < 16) return K_HIGH;
		else if (r < 17) return K_LOW;
		else if (r < 18) return K_WIDE;
		else return K_NOISE;
	endfunction

	function automatic logic [UnitW-1:0] pick_unit(unit_kind_t kind);
		logic [UnitW-1:0] cu;
		case (kind)
			K_ASCII: cu = UnitW'($urandom_range(0, 'h7F));
			K_TWO:   cu = UnitW'($urandom_range('h80, 'h7FF));
			K_BMP: begin
				cu = UnitW'($urandom_range('h800, 'hF7FF));
				if (cu >= SurrHiFirst)
					cu = cu + 21'h000800;
			end
			K_SUPP:  cu = UnitW'($urandom_range('h10000, 'h10FFFF));
			K_WIDE:  cu = UnitW'($urandom_range('h110000, 'h1FFFFF));
			K_PAIR, K_HIGH: cu = SurrHiFirst + UnitW'($urandom_range(0, 1023));
			K_LOW:   cu = SurrLoFirst + UnitW'($urandom_range(0, 1023));
			default: cu = UnitW'($urandom);
		endcase
		return cu;
	endfunction

	task automatic send_unit(logic [UnitW-1:0] cu, logic se);
		int gap;
		gap = draw_gap(tx_burst);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		code_unit  <= cu;
		string_end <= se;
		do @(posedge clk); while (in_stall);
		board.note_unit(cu, se);
		sent_units++;
	endtask

	task automatic send_string(int len);
		unit_kind_t kind;
		for (int i = 0; i < len; i++) begin
			kind = draw_kind();
			if (kind == K_PAIR && i < len - 1) begin
				send_unit(pick_unit(K_PAIR), 1'b0);
				i++;
				send_unit(pick_unit(K_LOW), i == len - 1);
			end else begin
				send_unit(pick_unit(kind), i == len - 1);
			end
		end
	endtask

	// The receiver holds off twice for a long stretch so the job queue fills
	// and the block stalls new requests.
	initial begin
		int n;
		wait (arst_n);
		forever begin
			if (got_bytes == 40 || got_bytes == 300)
				n = 250;
			else
				n = draw_gap(rx_burst);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			board.check_octet(utf8_byte, run_last, text_done);
			got_bytes++;
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		in_valid   = 1'b0;
		code_unit  = '0;
		string_end = 1'b0;
		out_stall  = 1'b0;
		arst_n     = 1'b0;
		sent_units = 0;
		got_bytes  = 0;
		tx_burst   = 0;
		rx_burst   = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_unit(21'h000000, 1'b0);
		send_unit(21'h00007F, 1'b0);
		send_unit(21'h000080, 1'b0);
		send_unit(21'h0007FF, 1'b0);
		send_unit(21'h000800, 1'b0);
		send_unit(21'h00D7FF, 1'b0);
		send_unit(21'h00E000, 1'b0);
		send_unit(21'h00FFFF, 1'b1);
		send_unit(21'h010000, 1'b0);
		send_unit(21'h10FFFF, 1'b0);
		send_unit(21'h110000, 1'b0);
		send_unit(21'h1FFFFF, 1'b1);
		send_unit(21'h00D800, 1'b0);
		send_unit(21'h00DC00, 1'b0);
		send_unit(21'h00DBFF, 1'b0);
		send_unit(21'h00DFFF, 1'b1);
		send_unit(21'h00D800, 1'b0);
		send_unit(21'h000041, 1'b0);
		send_unit(21'h00DBFF, 1'b0);
		send_unit(21'h10FFFF, 1'b0);
		send_unit(21'h00DA00, 1'b0);
		send_unit(21'h00DB00, 1'b0);
		send_unit(21'h00DC80, 1'b1);
		send_unit(21'h00DBFF, 1'b1);
		send_unit(21'h00DE00, 1'b1);
		send_unit(21'h00D900, 1'b0);
		send_unit(21'h00007F, 1'b1);

		while (sent_units < UnitTarget)
			send_string($urandom_range(1, 8));
		in_valid <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
